/* design/fsc_pkg.sv */
// shared types and constants of the frustum sphere cull block
package fsc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 64;

    localparam int MID_DEPTH  = 4;
    localparam int MID_AW     = $clog2(MID_DEPTH);
    localparam int MID_CW     = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_AW     = $clog2(OUT_DEPTH);
    localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_DW-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

    typedef logic signed [32:0] coef_t;

    typedef struct packed {
        coef_t a;
        coef_t b;
        coef_t c;
        coef_t d;
    } plane_t;

    typedef struct packed {
        plane_t [NUM_PLANES-1:0]        pl;
        logic [NUM_PLANES-1:0][65:0]    s;
        logic [NUM_PLANES-1:0]          zn;
    } info_t;

    typedef struct packed {
        logic [NUM_PLANES-1:0][66:0]    dq;
        logic [NUM_PLANES-1:0]          zn;
        logic [NUM_PLANES-1:0]          zrej;
        logic [61:0]                    r2;
    } mid_t;

endpackage

/* design/fsc_planes.sv */
// configuration registers and derived frustum planes
module fsc_planes (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fsc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [fsc_pkg::CFG_DW-1:0]   cfg_data,
    output fsc_pkg::info_t               info
);

    logic [fsc_pkg::CFG_DW-1:0] cfg_reg [fsc_pkg::NUM_REGS];
    fsc_pkg::coef_t             mx [4][4];
    fsc_pkg::coef_t             pc [fsc_pkg::NUM_PLANES][4];
    fsc_pkg::plane_t            pl_reg [fsc_pkg::NUM_PLANES];
    logic [65:0]                sq_reg [fsc_pkg::NUM_PLANES][3];
    logic [65:0]                s_reg [fsc_pkg::NUM_PLANES];
    logic [32:0]                mg [fsc_pkg::NUM_PLANES][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsc_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= fsc_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mx[r][0] = fsc_pkg::coef_t'($signed(cfg_reg[2*r][31:0]));
            mx[r][1] = fsc_pkg::coef_t'($signed(cfg_reg[2*r][63:32]));
            mx[r][2] = fsc_pkg::coef_t'($signed(cfg_reg[2*r+1][31:0]));
            mx[r][3] = fsc_pkg::coef_t'($signed(cfg_reg[2*r+1][63:32]));
        end
        for (int j = 0; j < 4; j++)
        begin
            pc[0][j] = mx[3][j] + mx[0][j];
            pc[1][j] = mx[3][j] - mx[0][j];
            pc[2][j] = mx[3][j] + mx[1][j];
            pc[3][j] = mx[3][j] - mx[1][j];
            pc[4][j] = mx[2][j];
            pc[5][j] = mx[3][j] - mx[2][j];
        end
        for (int k = 0; k < fsc_pkg::NUM_PLANES; k++)
        begin
            mg[k][0] = pl_reg[k].a[32] ? 33'(-pl_reg[k].a) : 33'(pl_reg[k].a);
            mg[k][1] = pl_reg[k].b[32] ? 33'(-pl_reg[k].b) : 33'(pl_reg[k].b);
            mg[k][2] = pl_reg[k].c[32] ? 33'(-pl_reg[k].c) : 33'(pl_reg[k].c);
        end
    end

    // pl_reg, sq_reg, s_reg settle after writes; user holds items till then
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < fsc_pkg::NUM_PLANES; k++)
        begin
            pl_reg[k].a <= pc[k][0];
            pl_reg[k].b <= pc[k][1];
            pl_reg[k].c <= pc[k][2];
            pl_reg[k].d <= pc[k][3];
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[k][j] <= 66'(mg[k][j]) * 66'(mg[k][j]);
            end
            s_reg[k] <= sq_reg[k][0] + sq_reg[k][1] + sq_reg[k][2];
        end
    end

    always_comb
    begin
        for (int k = 0; k < fsc_pkg::NUM_PLANES; k++)
        begin
            info.pl[k] = pl_reg[k];
            info.s[k]  = s_reg[k];
            info.zn[k] = (pl_reg[k].a == '0) && (pl_reg[k].b == '0) && (pl_reg[k].c == '0);
        end
    end

endmodule

/* design/fsc_front.sv */
// front pipeline: sphere intake, plane distances and zero-normal verdicts
module fsc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            center_x,
    input  logic signed [31:0]            center_y,
    input  logic signed [31:0]            center_z,
    input  logic [30:0]                   sphere_radius,
    input  fsc_pkg::info_t                info,
    input  logic [fsc_pkg::MID_CW-1:0]    mid_cnt,
    output logic                          mid_push,
    output fsc_pkg::mid_t                 mid_data
);

    logic               v0_reg;
    logic               v1_reg;
    logic               v0_next;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic [30:0]        r_reg;
    logic signed [64:0] prod_reg [fsc_pkg::NUM_PLANES][3];
    logic [fsc_pkg::NUM_PLANES-1:0] zn_reg;
    logic [fsc_pkg::NUM_PLANES-1:0] zrej_reg;
    logic [61:0]        r2_reg;
    logic signed [33:0] dr [fsc_pkg::NUM_PLANES];
    logic signed [66:0] dq [fsc_pkg::NUM_PLANES];
    logic [fsc_pkg::MID_CW:0] used;

    assign used = (fsc_pkg::MID_CW+1)'(mid_cnt) + (fsc_pkg::MID_CW+1)'(v0_reg)
                + (fsc_pkg::MID_CW+1)'(v1_reg);
    assign full    = used >= (fsc_pkg::MID_CW+1)'(fsc_pkg::MID_DEPTH);
    assign v0_next = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v0_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < fsc_pkg::NUM_PLANES; k++)
        begin
            dr[k] = 34'(info.pl[k].d) + $signed({3'b000, r_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (v0_next)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            cz_reg <= center_z;
            r_reg  <= sphere_radius;
        end
        for (int k = 0; k < fsc_pkg::NUM_PLANES; k++)
        begin
            prod_reg[k][0] <= 65'(info.pl[k].a) * 65'(cx_reg);
            prod_reg[k][1] <= 65'(info.pl[k].b) * 65'(cy_reg);
            prod_reg[k][2] <= 65'(info.pl[k].c) * 65'(cz_reg);
            zrej_reg[k]    <= dr[k][33];
        end
        zn_reg <= info.zn;
        r2_reg <= 62'(r_reg) * 62'(r_reg);
    end

    always_comb
    begin
        for (int k = 0; k < fsc_pkg::NUM_PLANES; k++)
        begin
            dq[k] = 67'(prod_reg[k][0]) + 67'(prod_reg[k][1]) + 67'(prod_reg[k][2])
                  + 67'($signed({info.pl[k].d, 16'h0000}));
            mid_data.dq[k] = dq[k];
        end
        mid_data.zn   = zn_reg;
        mid_data.zrej = zrej_reg;
        mid_data.r2   = r2_reg;
    end

    assign mid_push = v1_reg;

endmodule

/* design/fsc_fifo.sv */
// short queue between the front and back pipelines
module fsc_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr,
    input  fsc_pkg::mid_t                 wr_data,
    input  logic                          rd,
    output fsc_pkg::mid_t                 rd_data,
    output logic                          empty,
    output logic [fsc_pkg::MID_CW-1:0]    cnt
);

    fsc_pkg::mid_t                  mem [fsc_pkg::MID_DEPTH];
    logic [fsc_pkg::MID_AW-1:0]     wp_reg;
    logic [fsc_pkg::MID_AW-1:0]     rp_reg;
    logic [fsc_pkg::MID_CW-1:0]     cnt_reg;
    logic [fsc_pkg::MID_CW-1:0]     cnt_next;

    assign cnt_next = cnt_reg + fsc_pkg::MID_CW'(wr) - fsc_pkg::MID_CW'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rp_reg];
    assign empty   = cnt_reg == '0;
    assign cnt     = cnt_reg;

endmodule

/* design/fsc_back.sv */
// back pipeline: squared distance compare and result queue
module fsc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fsc_pkg::mid_t   mid_data,
    input  logic            mid_empty,
    output logic            mid_pop,
    input  fsc_pkg::info_t  info,
    input  logic            pop,
    output logic            empty,
    output logic            inside_res
);

    localparam int NP = fsc_pkg::NUM_PLANES;

    logic                   b1_reg;
    logic                   b2_reg;
    logic                   b3_reg;
    logic [65:0]            m_reg [NP];
    logic [63:0]            rsp_reg [NP][4];
    logic [65:0]            mp_reg [NP][3];
    logic [127:0]           rs2_reg [NP];
    logic [127:0]           rs3_reg [NP];
    logic [131:0]           m2_reg [NP];
    logic [NP-1:0]          neg1_reg, neg2_reg, neg3_reg;
    logic [NP-1:0]          zn1_reg, zn2_reg, zn3_reg;
    logic [NP-1:0]          zr1_reg, zr2_reg, zr3_reg;
    logic signed [66:0]     dqs [NP];
    logic signed [66:0]     dqn [NP];
    logic [NP-1:0]          rej;
    logic                   verdict;

    logic                       omem [fsc_pkg::OUT_DEPTH];
    logic [fsc_pkg::OUT_AW-1:0] wp_reg;
    logic [fsc_pkg::OUT_AW-1:0] rp_reg;
    logic [fsc_pkg::OUT_CW-1:0] ocnt_reg;
    logic [fsc_pkg::OUT_CW-1:0] ocnt_next;
    logic [fsc_pkg::OUT_CW:0]   used;
    logic                       rd;

    assign used = (fsc_pkg::OUT_CW+1)'(ocnt_reg) + (fsc_pkg::OUT_CW+1)'(b1_reg)
                + (fsc_pkg::OUT_CW+1)'(b2_reg) + (fsc_pkg::OUT_CW+1)'(b3_reg);
    assign mid_pop   = !mid_empty && (used < (fsc_pkg::OUT_CW+1)'(fsc_pkg::OUT_DEPTH));
    assign empty     = ocnt_reg == '0;
    assign rd        = pop && !empty;
    assign ocnt_next = ocnt_reg + fsc_pkg::OUT_CW'(b3_reg) - fsc_pkg::OUT_CW'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg   <= 1'b0;
            b2_reg   <= 1'b0;
            b3_reg   <= 1'b0;
            wp_reg   <= '0;
            rp_reg   <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            b1_reg <= mid_pop;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
            if (b3_reg)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NP; k++)
        begin
            dqs[k] = $signed(mid_data.dq[k]);
            dqn[k] = -dqs[k];
            rej[k] = zn3_reg[k] ? zr3_reg[k]
                                : (neg3_reg[k] && (m2_reg[k] > {4'h0, rs3_reg[k]}));
        end
        verdict = ~|rej;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NP; k++)
        begin
            // stage 1: magnitude of the distance, partial products of r^2 * |n|^2
            m_reg[k]      <= dqs[k][66] ? dqn[k][65:0] : dqs[k][65:0];
            rsp_reg[k][0] <= 64'(mid_data.r2[30:0])  * 64'(info.s[k][32:0]);
            rsp_reg[k][1] <= 64'(mid_data.r2[30:0])  * 64'(info.s[k][65:33]);
            rsp_reg[k][2] <= 64'(mid_data.r2[61:31]) * 64'(info.s[k][32:0]);
            rsp_reg[k][3] <= 64'(mid_data.r2[61:31]) * 64'(info.s[k][65:33]);
            // stage 2: partial products of the squared distance, sum of r^2 * |n|^2
            mp_reg[k][0] <= 66'(m_reg[k][32:0])  * 66'(m_reg[k][32:0]);
            mp_reg[k][1] <= 66'(m_reg[k][32:0])  * 66'(m_reg[k][65:33]);
            mp_reg[k][2] <= 66'(m_reg[k][65:33]) * 66'(m_reg[k][65:33]);
            rs2_reg[k] <= 128'(rsp_reg[k][0])
                        + {31'h0, rsp_reg[k][1], 33'h0}
                        + {33'h0, rsp_reg[k][2], 31'h0}
                        + {rsp_reg[k][3], 64'h0};
            // stage 3
            m2_reg[k] <= 132'(mp_reg[k][0])
                       + {32'h0, mp_reg[k][1], 34'h0}
                       + {mp_reg[k][2], 66'h0};
            rs3_reg[k] <= rs2_reg[k];
        end
        neg1_reg <= {mid_data.dq[5][66], mid_data.dq[4][66], mid_data.dq[3][66],
                     mid_data.dq[2][66], mid_data.dq[1][66], mid_data.dq[0][66]};
        zn1_reg  <= mid_data.zn;
        zr1_reg  <= mid_data.zrej;
        neg2_reg <= neg1_reg;
        zn2_reg  <= zn1_reg;
        zr2_reg  <= zr1_reg;
        neg3_reg <= neg2_reg;
        zn3_reg  <= zn2_reg;
        zr3_reg  <= zr2_reg;
        if (b3_reg)
        begin
            omem[wp_reg] <= verdict;
        end
    end

    assign inside_res = omem[rp_reg];

endmodule

/* design/frustum_sphere_cull_core.sv */
// top level of the frustum sphere cull block
//
// input channel: push with center_x/y/z and sphere_radius; a request is
// taken when push is high and full is low. result channel: inside_res is
// valid while empty is low and is taken when pop is high.
// configuration: cfg_we writes cfg_data into matrix register cfg_index;
// planes are registered in pl_reg and squared normal lengths pass sq_reg then s_reg.
// path from an accepted request to its result: front pipeline of two
// stages, a four-entry queue, back pipeline of three stages and an
// eight-entry result queue.
// throughput: one sphere per cycle while full stays low, set by the fully
// pipelined per-plane multipliers in both halves.
// reset: all queues are emptied and the matrix returns to identity.
// a stalled receiver fills the result queue; the back pipeline then stops
// drawing from the middle queue, which in turn raises full.
module frustum_sphere_cull_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fsc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [fsc_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic signed [31:0]          center_x,
    input  logic signed [31:0]          center_y,
    input  logic signed [31:0]          center_z,
    input  logic [30:0]                 sphere_radius,
    output logic                        empty,
    input  logic                        pop,
    output logic                        inside_res
);

    fsc_pkg::info_t                 info;
    fsc_pkg::mid_t                  fr_data;
    fsc_pkg::mid_t                  bk_data;
    logic                           fr_push;
    logic                           bk_pop;
    logic                           mid_empty;
    logic [fsc_pkg::MID_CW-1:0]     mid_cnt;

    fsc_planes u_planes (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .info      (info)
    );

    fsc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .info          (info),
        .mid_cnt       (mid_cnt),
        .mid_push      (fr_push),
        .mid_data      (fr_data)
    );

    fsc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fr_push),
        .wr_data (fr_data),
        .rd      (bk_pop),
        .rd_data (bk_data),
        .empty   (mid_empty),
        .cnt     (mid_cnt)
    );

    fsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_data   (bk_data),
        .mid_empty  (mid_empty),
        .mid_pop    (bk_pop),
        .info       (info),
        .pop        (pop),
        .empty      (empty),
        .inside_res (inside_res)
    );

endmodule

/* design/fsc_checker.sv */
// port-level assertions for the frustum sphere cull block
module fsc_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic inside_res
);

    // reset empties both queues
    a_reset_state: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not empty during reset");

    // a waiting result stays until it is taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(inside_res)))
        else $error("waiting result lost or changed");

    // the first cycle out of reset shows an idle block
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> (empty && !full))
        else $error("block not idle after reset");

    // nothing pushed into an idle block cannot yield a result next cycle
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push && $past(empty) && $past(!push, 1) && $past(!full, 1)
         && $past(empty, 2) && $past(!push, 2) && $past(empty, 3) && $past(!push, 3)
         && $past(empty, 4) && $past(!push, 4) && $past(empty, 5) && $past(!push, 5)
         && $past(empty, 6) && $past(!push, 6) && $past(rst_n, 6))
        |=> empty)
        else $error("result appeared with nothing in flight");

endmodule

bind frustum_sphere_cull_core fsc_checker u_fsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .inside_res (inside_res)
);
